// File: hw/rtl/btp_pkg.sv
// Shared constants, widths and types for the blended trajectory point pipeline.
// No dependencies; every other file of the block imports this package.
package btp_pkg;

   localparam int POS_W   = 32;            // Q16.16 position
   localparam int MAG_W   = 32;            // |end - start|
   localparam int CNT_W   = 13;            // point count
   localparam int IDX_W   = 12;            // point index, n - 1, n - 1 - i
   localparam int THR_W   = 16;            // still threshold
   localparam int FRAC_W  = 32;            // fraction bits of the blend fraction
   localparam int BETA_W  = 28;
   localparam int BETAM_W = BETA_W + IDX_W;
   localparam int SQ_W    = 2 * IDX_W;
   localparam int SQ10_W  = SQ_W + 4;
   localparam int C_W     = 30;
   localparam int LIN_W   = C_W + IDX_W;
   localparam int NUM_W   = MAG_W + SQ10_W;
   localparam int DEN_W   = SQ_W;
   localparam int QUO_W   = 30;            // both quotients stay below 2^30
   localparam int PROD_W  = MAG_W + QUO_W;
   localparam int HALF_SH = 29;
   localparam int SUM_SH  = 30;

   localparam int MAX_POINTS = 4096;
   localparam logic [CNT_W-1:0]  MAX_COUNT   = CNT_W'(MAX_POINTS);
   localparam logic [BETA_W-1:0] BETA_Q32    = 28'd226715881;
   localparam logic [C_W-1:0]    C_Q30       = 30'd566789703;
   localparam logic [THR_W-1:0]  STILL_RESET = 16'd66;

   typedef enum logic [1:0] {
      MODE_START,
      MODE_END,
      MODE_LINEAR
   } btp_mode_type;

   // Per-item control and operands that ride alongside the arithmetic
   typedef struct packed {
      logic               err;
      logic               still;
      logic               neg;
      btp_mode_type       mode;
      logic               wneg;
      logic [POS_W-1:0]   qi;
      logic [MAG_W-1:0]   a;
   } btp_side_type;

endpackage

// File: hw/rtl/btp_prep.sv
// Front end of the trajectory pipeline: distance, segment selection and the
// dividend / divisor for the shared divider. Six register stages. Uses btp_pkg.
module btp_prep import btp_pkg::*; (
   input  logic               clock,
   input  logic               reset,
   input  logic               adv,
   input  logic               in_valid,
   input  logic [POS_W-1:0]   start_pos,
   input  logic [POS_W-1:0]   end_pos,
   input  logic [CNT_W-1:0]   point_count,
   input  logic [IDX_W-1:0]   point_index,
   input  logic [THR_W-1:0]   still_threshold,
   output logic               out_valid,
   output logic [NUM_W-1:0]   num,
   output logic [DEN_W-1:0]   den,
   output btp_side_type       side
);

   // stage 1
   logic               p1_valid_ff;
   logic [POS_W:0]     p1_diff_ff, p1_diff_in;
   logic [POS_W-1:0]   p1_qi_ff;
   logic [CNT_W-1:0]   p1_n_ff;
   logic [IDX_W-1:0]   p1_i_ff;
   logic               p1_err_ff, p1_err_in;

   // stage 2
   logic               p2_valid_ff;
   logic [POS_W:0]     p2_mag;
   logic [CNT_W-1:0]   p2_m_full;
   logic [MAG_W-1:0]   p2_a_ff, p2_a_in;
   logic               p2_neg_ff, p2_still_ff, p2_still_in, p2_err_ff;
   logic [POS_W-1:0]   p2_qi_ff;
   logic [IDX_W-1:0]   p2_i_ff, p2_m_ff, p2_m_in, p2_k_ff, p2_k_in;
   logic [BETAM_W-1:0] p2_betam_ff, p2_betam_in;

   // stage 3
   logic               p3_valid_ff;
   logic               p3_start_hit, p3_end_hit;
   logic [IDX_W:0]     p3_two_i, p3_m_ext, p3_w_full;
   btp_side_type       p3_side_ff, p3_side_in;
   logic [SQ_W-1:0]    p3_sq_i_ff, p3_sq_i_in, p3_sq_k_ff, p3_sq_k_in, p3_m2_ff, p3_m2_in;
   logic [IDX_W-1:0]   p3_w_ff, p3_m_ff;

   // stage 4
   logic               p4_valid_ff;
   logic [SQ_W-1:0]    p4_sq;
   btp_side_type       p4_side_ff;
   logic [SQ10_W-1:0]  p4_sq10_ff, p4_sq10_in;
   logic [LIN_W-1:0]   p4_lin_ff, p4_lin_in;
   logic [DEN_W-1:0]   p4_den_ff, p4_den_in;

   // stage 5
   logic               p5_valid_ff;
   btp_side_type       p5_side_ff;
   logic [NUM_W-1:0]   p5_prod_ff, p5_prod_in;
   logic [LIN_W-1:0]   p5_lin_ff;
   logic [DEN_W-1:0]   p5_den_ff;

   // stage 6
   logic               p6_valid_ff;
   logic [NUM_W-1:0]   p6_base;
   btp_side_type       p6_side_ff;
   logic [NUM_W-1:0]   p6_num_ff, p6_num_in;
   logic [DEN_W-1:0]   p6_den_ff;

   always_comb begin
      p1_diff_in = {end_pos[POS_W-1], end_pos} - {start_pos[POS_W-1], start_pos};
      p1_err_in  = ({1'b0, point_index} >= point_count) || (point_count > MAX_COUNT);
   end

   always_comb begin
      p2_mag      = p1_diff_ff[POS_W] ? (~p1_diff_ff + 1'b1) : p1_diff_ff;
      p2_a_in     = p2_mag[MAG_W-1:0];
      p2_still_in = (p2_a_in <= MAG_W'(still_threshold)) || (p1_n_ff == CNT_W'(1));
      p2_m_full   = p1_n_ff - CNT_W'(1);
      p2_m_in     = p2_m_full[IDX_W-1:0];
      p2_k_in     = p2_m_in - p1_i_ff;
      p2_betam_in = BETAM_W'(BETA_Q32) * BETAM_W'(p2_m_in);
   end

   always_comb begin
      p3_start_hit = {p2_i_ff, {FRAC_W{1'b0}}} <= (IDX_W + FRAC_W)'(p2_betam_ff);
      p3_end_hit   = {p2_k_ff, {FRAC_W{1'b0}}} <= (IDX_W + FRAC_W)'(p2_betam_ff);
      p3_two_i     = {p2_i_ff, 1'b0};
      p3_m_ext     = {1'b0, p2_m_ff};
      p3_side_in.err   = p2_err_ff;
      p3_side_in.still = p2_still_ff;
      p3_side_in.neg   = p2_neg_ff;
      p3_side_in.qi    = p2_qi_ff;
      p3_side_in.a     = p2_a_ff;
      p3_side_in.wneg  = p3_two_i < p3_m_ext;
      p3_w_full = p3_side_in.wneg ? (p3_m_ext - p3_two_i) : (p3_two_i - p3_m_ext);
      // start blend wins over end blend
      if (p3_start_hit) begin
         p3_side_in.mode = MODE_START;
      end else if (p3_end_hit) begin
         p3_side_in.mode = MODE_END;
      end else begin
         p3_side_in.mode = MODE_LINEAR;
      end
      p3_sq_i_in = SQ_W'(p2_i_ff) * SQ_W'(p2_i_ff);
      p3_sq_k_in = SQ_W'(p2_k_ff) * SQ_W'(p2_k_ff);
      p3_m2_in   = SQ_W'(p2_m_ff) * SQ_W'(p2_m_ff);
   end

   always_comb begin
      p4_sq      = (p3_side_ff.mode == MODE_END) ? p3_sq_k_ff : p3_sq_i_ff;
      p4_sq10_in = SQ10_W'({p4_sq, 3'b000}) + SQ10_W'({p4_sq, 1'b0});
      p4_lin_in  = LIN_W'(C_Q30) * LIN_W'(p3_w_ff);
      p4_den_in  = (p3_side_ff.mode == MODE_LINEAR) ? DEN_W'(p3_m_ff) : p3_m2_ff;
   end

   assign p5_prod_in = NUM_W'(p4_side_ff.a) * NUM_W'(p4_sq10_ff);

   always_comb begin
      p6_base   = (p5_side_ff.mode == MODE_LINEAR) ? NUM_W'(p5_lin_ff) : p5_prod_ff;
      // add half the divisor so the quotient rounds to nearest, halves up
      p6_num_in = p6_base + NUM_W'(p5_den_ff >> 1);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         p1_valid_ff <= 1'b0;
         p2_valid_ff <= 1'b0;
         p3_valid_ff <= 1'b0;
         p4_valid_ff <= 1'b0;
         p5_valid_ff <= 1'b0;
         p6_valid_ff <= 1'b0;
      end else if (adv) begin
         p1_valid_ff <= in_valid;
         p2_valid_ff <= p1_valid_ff;
         p3_valid_ff <= p2_valid_ff;
         p4_valid_ff <= p3_valid_ff;
         p5_valid_ff <= p4_valid_ff;
         p6_valid_ff <= p5_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         p1_diff_ff  <= p1_diff_in;
         p1_qi_ff    <= start_pos;
         p1_n_ff     <= point_count;
         p1_i_ff     <= point_index;
         p1_err_ff   <= p1_err_in;

         p2_a_ff     <= p2_a_in;
         p2_neg_ff   <= p1_diff_ff[POS_W];
         p2_still_ff <= p2_still_in;
         p2_err_ff   <= p1_err_ff;
         p2_qi_ff    <= p1_qi_ff;
         p2_i_ff     <= p1_i_ff;
         p2_m_ff     <= p2_m_in;
         p2_k_ff     <= p2_k_in;
         p2_betam_ff <= p2_betam_in;

         p3_side_ff  <= p3_side_in;
         p3_sq_i_ff  <= p3_sq_i_in;
         p3_sq_k_ff  <= p3_sq_k_in;
         p3_m2_ff    <= p3_m2_in;
         p3_w_ff     <= p3_w_full[IDX_W-1:0];
         p3_m_ff     <= p2_m_ff;

         p4_side_ff  <= p3_side_ff;
         p4_sq10_ff  <= p4_sq10_in;
         p4_lin_ff   <= p4_lin_in;
         p4_den_ff   <= p4_den_in;

         p5_side_ff  <= p4_side_ff;
         p5_prod_ff  <= p5_prod_in;
         p5_lin_ff   <= p4_lin_ff;
         p5_den_ff   <= p4_den_ff;

         p6_side_ff  <= p5_side_ff;
         p6_num_ff   <= p6_num_in;
         p6_den_ff   <= p5_den_ff;
      end
   end

   assign out_valid = p6_valid_ff;
   assign num       = p6_num_ff;
   assign den       = p6_den_ff;
   assign side      = p6_side_ff;

endmodule

// File: hw/rtl/btp_div.sv
// Pipelined restoring divider: one quotient bit per register stage, QUO_W
// stages, with the item's control travelling beside it. Uses btp_pkg.
module btp_div import btp_pkg::*; (
   input  logic               clock,
   input  logic               reset,
   input  logic               adv,
   input  logic               in_valid,
   input  logic [NUM_W-1:0]   num,
   input  logic [DEN_W-1:0]   den,
   input  btp_side_type       in_side,
   output logic               out_valid,
   output logic [QUO_W-1:0]   quo,
   output btp_side_type       out_side
);

   logic               vld_ff  [QUO_W];
   logic [NUM_W-1:0]   rem_ff  [QUO_W];
   logic [DEN_W-1:0]   den_ff  [QUO_W];
   logic [QUO_W-1:0]   quo_ff  [QUO_W];
   btp_side_type       side_ff [QUO_W];

   for (genvar s = 0; s < QUO_W; s++) begin : g_stage
      logic               prev_vld;
      logic [NUM_W-1:0]   prev_rem;
      logic [DEN_W-1:0]   prev_den;
      logic [QUO_W-1:0]   prev_quo;
      btp_side_type       prev_side;
      logic [NUM_W-1:0]   shifted;
      logic               take;
      logic [NUM_W-1:0]   rem_in;
      logic [QUO_W-1:0]   quo_in;

      if (s == 0) begin : g_first
         assign prev_vld  = in_valid;
         assign prev_rem  = num;
         assign prev_den  = den;
         assign prev_quo  = '0;
         assign prev_side = in_side;
      end else begin : g_next
         assign prev_vld  = vld_ff[s-1];
         assign prev_rem  = rem_ff[s-1];
         assign prev_den  = den_ff[s-1];
         assign prev_quo  = quo_ff[s-1];
         assign prev_side = side_ff[s-1];
      end

      always_comb begin
         shifted = NUM_W'(prev_den) << (QUO_W - 1 - s);
         take    = prev_rem >= shifted;
         rem_in  = take ? (prev_rem - shifted) : prev_rem;
         quo_in  = {prev_quo[QUO_W-2:0], take};
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            vld_ff[s] <= 1'b0;
         end else if (adv) begin
            vld_ff[s] <= prev_vld;
         end
      end

      always_ff @(posedge clock) begin
         if (adv) begin
            rem_ff[s]  <= rem_in;
            den_ff[s]  <= prev_den;
            quo_ff[s]  <= quo_in;
            side_ff[s] <= prev_side;
         end
      end
   end

   assign out_valid = vld_ff[QUO_W-1];
   assign quo       = quo_ff[QUO_W-1];
   assign out_side  = side_ff[QUO_W-1];

endmodule

// File: hw/rtl/btp_post.sv
// Back end of the trajectory pipeline: turns the quotient into the move
// magnitude for the blend or linear segment. Three register stages. Uses btp_pkg.
module btp_post import btp_pkg::*; (
   input  logic               clock,
   input  logic               reset,
   input  logic               adv,
   input  logic               in_valid,
   input  logic [QUO_W-1:0]   quo,
   input  btp_side_type       in_side,
   output logic               out_valid,
   output logic [MAG_W-1:0]   mag,
   output btp_side_type       out_side
);

   logic               b1_valid_ff;
   btp_side_type       b1_side_ff;
   logic [PROD_W-1:0]  b1_prod_ff, b1_prod_in;
   logic [MAG_W-1:0]   b1_blend_ff, b1_blend_in;

   logic               b2_valid_ff;
   btp_side_type       b2_side_ff;
   logic [PROD_W-1:0]  b2_half;
   logic [PROD_W:0]    b2_diff;
   logic [PROD_W-1:0]  b2_t_ff, b2_t_in;
   logic [MAG_W-1:0]   b2_blend_ff;

   logic               b3_valid_ff;
   btp_side_type       b3_side_ff;
   logic [PROD_W:0]    b3_round;
   logic [MAG_W-1:0]   b3_mag_ff, b3_mag_in;

   always_comb begin
      b1_prod_in  = PROD_W'(in_side.a) * PROD_W'(quo);
      // end blend counts back from the far end
      b1_blend_in = (in_side.mode == MODE_END) ? (in_side.a - MAG_W'(quo)) : MAG_W'(quo);
   end

   always_comb begin
      b2_half = PROD_W'(b1_side_ff.a) << HALF_SH;
      b2_diff = {1'b0, b2_half} - {1'b0, b1_prod_ff};
      if (b1_side_ff.wneg) begin
         // clamp at zero below the midpoint
         b2_t_in = b2_diff[PROD_W] ? '0 : b2_diff[PROD_W-1:0];
      end else begin
         b2_t_in = b2_half + b1_prod_ff;
      end
   end

   always_comb begin
      b3_round  = {1'b0, b2_t_ff} + ((PROD_W + 1)'(1) << HALF_SH);
      b3_mag_in = (b2_side_ff.mode == MODE_LINEAR) ? b3_round[SUM_SH +: MAG_W] : b2_blend_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         b1_valid_ff <= 1'b0;
         b2_valid_ff <= 1'b0;
         b3_valid_ff <= 1'b0;
      end else if (adv) begin
         b1_valid_ff <= in_valid;
         b2_valid_ff <= b1_valid_ff;
         b3_valid_ff <= b2_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         b1_side_ff  <= in_side;
         b1_prod_ff  <= b1_prod_in;
         b1_blend_ff <= b1_blend_in;
         b2_side_ff  <= b1_side_ff;
         b2_t_ff     <= b2_t_in;
         b2_blend_ff <= b1_blend_ff;
         b3_side_ff  <= b2_side_ff;
         b3_mag_ff   <= b3_mag_in;
      end
   end

   assign out_valid = b3_valid_ff;
   assign mag       = b3_mag_ff;
   assign out_side  = b3_side_ff;

endmodule

// File: hw/rtl/blended_trajectory_point.sv
// Blended trajectory point top level: front end, divider, back end, output register.
// Depends on btp_pkg, btp_prep, btp_div and btp_post.
//
// Each request transaction asks for point i of an n-point move between two
// signed Q16.16 positions, shaped as a parabolic start blend, a linear middle
// and a parabolic end blend (blend factor 5). Time is i/(n-1) taken exactly,
// and every point is rounded to nearest, symmetrically about zero. One request
// is accepted per clock while the response side does not stall; each gives
// exactly one response transaction after six front-end stages, one stage per
// quotient bit of the 30-stage divider, three back-end stages and the output
// register. A stall on the response side holds the whole pipeline,
// so req_tready follows rsp_tready while a response is waiting. An index not
// below the count, or a count above 4096, returns position 0 with rsp_tuser
// set. A count of one, or a move no longer than still_threshold (csr_tdata,
// Q16.16, reset 66), returns the start position. Write the threshold only
// while no request is in flight.
module blended_trajectory_point import btp_pkg::*; (
   input  logic          clock,
   input  logic          reset,
   input  logic          req_tvalid,
   output logic          req_tready,
   // [31:0] start_pos, [63:32] end_pos, [76:64] point_count,
   // [88:77] point_index, [95:89] zero
   input  logic [95:0]   req_tdata,
   output logic          rsp_tvalid,
   input  logic          rsp_tready,
   // [31:0] position
   output logic [31:0]   rsp_tdata,
   // [0] index_error
   output logic [0:0]    rsp_tuser,
   input  logic          csr_tvalid,
   output logic          csr_tready,
   // [15:0] still_threshold
   input  logic [15:0]   csr_tdata
);

   localparam int START_LO = 0;
   localparam int END_LO   = START_LO + POS_W;
   localparam int COUNT_LO = END_LO + POS_W;
   localparam int INDEX_LO = COUNT_LO + CNT_W;

   logic               adv;
   logic [THR_W-1:0]   thr_ff;

   logic               prep_valid;
   logic [NUM_W-1:0]   prep_num;
   logic [DEN_W-1:0]   prep_den;
   btp_side_type       prep_side;

   logic               div_valid;
   logic [QUO_W-1:0]   div_quo;
   btp_side_type       div_side;

   logic               post_valid;
   logic [MAG_W-1:0]   post_mag;
   btp_side_type       post_side;

   logic               rsp_valid_ff;
   logic [POS_W-1:0]   rsp_pos_ff, rsp_pos_in;
   logic               rsp_err_ff;

   // advance everything unless a finished response is held back
   assign adv        = !rsp_valid_ff || rsp_tready;
   assign req_tready = adv;
   assign csr_tready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         thr_ff <= STILL_RESET;
      end else if (csr_tvalid) begin
         thr_ff <= csr_tdata;
      end
   end

   btp_prep u_prep (
      .clock           (clock),
      .reset           (reset),
      .adv             (adv),
      .in_valid        (req_tvalid),
      .start_pos       (req_tdata[START_LO +: POS_W]),
      .end_pos         (req_tdata[END_LO +: POS_W]),
      .point_count     (req_tdata[COUNT_LO +: CNT_W]),
      .point_index     (req_tdata[INDEX_LO +: IDX_W]),
      .still_threshold (thr_ff),
      .out_valid       (prep_valid),
      .num             (prep_num),
      .den             (prep_den),
      .side            (prep_side)
   );

   btp_div u_div (
      .clock     (clock),
      .reset     (reset),
      .adv       (adv),
      .in_valid  (prep_valid),
      .num       (prep_num),
      .den       (prep_den),
      .in_side   (prep_side),
      .out_valid (div_valid),
      .quo       (div_quo),
      .out_side  (div_side)
   );

   btp_post u_post (
      .clock     (clock),
      .reset     (reset),
      .adv       (adv),
      .in_valid  (div_valid),
      .quo       (div_quo),
      .in_side   (div_side),
      .out_valid (post_valid),
      .mag       (post_mag),
      .out_side  (post_side)
   );

   // apply the sign of the move to the magnitude; the sum never leaves 32 bits
   always_comb begin
      if (post_side.err) begin
         rsp_pos_in = '0;
      end else if (post_side.still) begin
         rsp_pos_in = post_side.qi;
      end else if (post_side.neg) begin
         rsp_pos_in = post_side.qi - post_mag;
      end else begin
         rsp_pos_in = post_side.qi + post_mag;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (adv) begin
         rsp_valid_ff <= post_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         rsp_pos_ff <= rsp_pos_in;
         rsp_err_ff <= post_side.err;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_pos_ff;
   assign rsp_tuser  = rsp_err_ff;

endmodule

// File: bench/tb_top.sv
`timescale 1ns / 1ps
// Self-checking bench for blended_trajectory_point: a scoreboard class predicts every point.
// Depends on btp_pkg for the blend constants and on the block's top-level port list.

typedef struct packed {
   logic [31:0] position;
   logic        index_error;
} point_result_type;

class traj_scoreboard_type;
   bit [15:0]        still_threshold;
   point_result_type pending_points[$];
   int unsigned      fail_count;

   function new();
      still_threshold = btp_pkg::STILL_RESET;
      fail_count      = 0;
   endfunction

   // round(a * 10 * k^2 / m^2), halves up
   function bit [63:0] blend_magnitude(bit [63:0] a, bit [63:0] k, bit [63:0] m);
      bit [63:0] num;
      bit [63:0] den;
      num = a * 64'd10 * k * k;
      den = m * m;
      return (num + den / 2) / den;
   endfunction

   function point_result_type predict_point(bit [95:0] word);
      bit signed [31:0] qi;
      bit signed [31:0] qf;
      bit [12:0]        n;
      bit [11:0]        i;
      longint           d;
      longint           p;
      bit               neg;
      bit               wneg;
      bit [63:0]        a, m, k, v, w, g, half, prod, t, two_i;
      point_result_type r;
      qi  = word[31:0];
      qf  = word[63:32];
      n   = word[76:64];
      i   = word[88:77];
      d   = longint'(qf) - longint'(qi);
      neg = d < 0;
      a   = neg ? 64'(-d) : 64'(d);
      r   = '0;
      if (i >= n || n > btp_pkg::MAX_POINTS) begin
         r.index_error = 1'b1;
         return r;
      end
      if (a <= 64'(still_threshold) || n == 13'd1) begin
         r.position = qi;
         return r;
      end
      m = 64'(n) - 64'd1;
      k = m - 64'(i);
      if ((64'(i) << 32) <= 64'(btp_pkg::BETA_Q32) * m) begin
         v = blend_magnitude(a, 64'(i), m);
      end else if ((k << 32) <= 64'(btp_pkg::BETA_Q32) * m) begin
         v = a - blend_magnitude(a, k, m);
      end else begin
         two_i = 64'(i) * 64'd2;
         wneg  = two_i < m;
         w     = wneg ? m - two_i : two_i - m;
         g     = (64'(btp_pkg::C_Q30) * w + m / 2) / m;
         half  = a << btp_pkg::HALF_SH;
         prod  = a * g;
         if (wneg) t = (prod > half) ? 64'd0 : half - prod;
         else t = half + prod;
         v = (t + (64'd1 << btp_pkg::HALF_SH)) >> btp_pkg::SUM_SH;
      end
      p = neg ? longint'(qi) - longint'(v) : longint'(qi) + longint'(v);
      r.position = p[31:0];
      return r;
   endfunction

   function void note_request(bit [95:0] word);
      pending_points.push_back(predict_point(word));
   endfunction

   function void check_response(bit [31:0] position, bit index_error);
      point_result_type exp_pt;
      if (pending_points.size() == 0) begin
         $error("response transaction with no prediction waiting: position %h", position);
         fail_count++;
         return;
      end
      exp_pt = pending_points.pop_front();
      if (position !== exp_pt.position) begin
         $error("position mismatch: expected %h, actual %h", exp_pt.position, position);
         fail_count++;
      end
      if (index_error !== exp_pt.index_error) begin
         $error("index_error mismatch: expected %0d, actual %0d",
                exp_pt.index_error, index_error);
         fail_count++;
      end
   endfunction

   function int unsigned outstanding();
      return pending_points.size();
   endfunction
endclass

module tb_top;
   import btp_pkg::*;

   localparam int PIPE_LATENCY  = 40;     // request to response with no stall
   localparam int IDLE_LIMIT    = 4000;   // cycles without any transaction
   localparam int PHASE_ITEMS   = 300;
   localparam int PHASE_COUNT   = 6;

   logic        clock;
   logic        reset;
   logic        req_tvalid;
   logic        req_tready;
   logic [95:0] req_tdata;     // start_pos, end_pos, point_count, point_index, zero pad
   logic        rsp_tvalid;
   logic        rsp_tready;
   logic [31:0] rsp_tdata;     // position
   logic [0:0]  rsp_tuser;     // index_error
   logic        csr_tvalid;
   logic        csr_tready;
   logic [15:0] csr_tdata;     // still_threshold

   traj_scoreboard_type sb = new();

   bit          no_gaps;
   int unsigned idle_cycles;

   blended_trajectory_point u_top (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .csr_tvalid (csr_tvalid),
      .csr_tready (csr_tready),
      .csr_tdata  (csr_tdata)
   );

   initial clock = 1'b0;
   always #5 clock = ~clock;

   // Mostly short gaps, now and then a long one
   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (r < 55) return 0;
      if (r < 85) return $urandom_range(1, 3);
      if (r < 97) return $urandom_range(4, 15);
      return $urandom_range(30, 120);
   endfunction

   function automatic bit [31:0] pick_edge();
      case ($urandom_range(0, 3))
         0: return 32'h8000_0000;
         1: return 32'h7FFF_FFFF;
         2: return 32'h0000_0000;
         default: return 32'hFFFF_FFFF;
      endcase
   endfunction

   // Sample every transaction at the rising edge; inputs only move on the falling edge,
   // so the pre-edge values seen here are the ones the block acts on.
   always @(posedge clock) begin
      if (!reset) begin
         if (req_tvalid && req_tready) sb.note_request(req_tdata);
         if (rsp_tvalid && rsp_tready) sb.check_response(rsp_tdata, rsp_tuser[0]);
         if (csr_tvalid && csr_tready) sb.still_threshold = csr_tdata;
      end
   end

   // Watchdog: count cycles in which no channel completes a transaction
   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) ||
          (csr_tvalid && csr_tready)) begin
         idle_cycles <= 0;
      end else begin
         idle_cycles <= idle_cycles + 1;
         if (idle_cycles + 1 >= IDLE_LIMIT) begin
            $display("TEST FAILED");
            $finish;
         end
      end
   end

   // Response side back-pressure: ready stretches of random length, broken by stalls.
   // An occasional long ready stretch leaves the pipeline running free.
   initial begin
      int hold;
      int stall;
      rsp_tready = 1'b0;
      forever begin
         hold  = ($urandom_range(0, 9) == 0) ? $urandom_range(100, 300)
                                             : $urandom_range(1, 20);
         stall = pick_gap();
         @(negedge clock);
         rsp_tready <= 1'b1;
         repeat (hold - 1) @(negedge clock);
         if (stall > 0) begin
            @(negedge clock);
            rsp_tready <= 1'b0;
            repeat (stall - 1) @(negedge clock);
         end
      end
   end

   // Drop valid for a random gap (unless gaps are off), then hold one request
   // transaction on the bus until it is accepted.
   task automatic send_request(bit [31:0] start_pos, bit [31:0] end_pos,
                               bit [12:0] point_count, bit [11:0] point_index);
      int gap;
      gap = no_gaps ? 0 : pick_gap();
      if (gap > 0) begin
         @(negedge clock);
         req_tvalid <= 1'b0;
         repeat (gap - 1) @(negedge clock);
      end
      @(negedge clock);
      req_tvalid <= 1'b1;
      req_tdata  <= {7'd0, point_index, point_count, end_pos, start_pos};
      do @(posedge clock); while (!req_tready);
   endtask

   // Hold the sender off until every predicted point has come back
   task automatic drain_pipeline();
      @(negedge clock);
      req_tvalid <= 1'b0;
      while (sb.outstanding() != 0) @(negedge clock);
   endtask

   // Write the threshold; only called with the pipeline empty
   task automatic write_threshold(bit [15:0] value);
      repeat (4) @(negedge clock);
      csr_tvalid <= 1'b1;
      csr_tdata  <= value;
      do @(posedge clock); while (!csr_tready);
      @(negedge clock);
      csr_tvalid <= 1'b0;
   endtask

   // One random request: mostly well-formed points of a move, some short moves near
   // the threshold, some extreme positions, and a share of out-of-range noise.
   task automatic random_request();
      bit [31:0] s;
      bit [31:0] e;
      bit [12:0] n;
      bit [11:0] i;
      int        sel;
      int        cnt;
      int        idx;
      int        delta;
      int        last;
      s = $urandom;
      e = $urandom;
      case ($urandom_range(0, 9))
         5, 6: begin
            // Move close to the still threshold, kept clear of wrap-around
            s = $urandom;
            s = {{2{s[29]}}, s[29:0]};
            delta = $urandom_range(0, int'(sb.still_threshold) + 3);
            e = $urandom_range(0, 1) ? s + 32'(delta) : s - 32'(delta);
         end
         7: begin
            s = pick_edge();
            e = $urandom_range(0, 1) ? pick_edge() : $urandom;
         end
         8, 9: begin
            s = $urandom;
            e = $urandom;
            s = {{2{s[29]}}, s[29:0]};
            e = {{2{e[29]}}, e[29:0]};
         end
         default: ;
      endcase
      sel = $urandom_range(0, 99);
      if (sel < 75) begin
         cnt  = $urandom_range(2, MAX_POINTS);
         last = cnt - 1;
         case ($urandom_range(0, 3))
            0: idx = $urandom_range(0, last / 16);
            1: idx = last - $urandom_range(0, last / 16);
            default: idx = $urandom_range(0, last);
         endcase
         n = 13'(cnt);
         i = 12'(idx);
      end else if (sel < 85) begin
         cnt = $urandom_range(1, 8);
         n   = 13'(cnt);
         i   = 12'($urandom_range(0, cnt - 1));
      end else begin
         n = 13'($urandom);
         i = 12'($urandom);
      end
      send_request(s, e, n, i);
   endtask

   initial begin
      bit [15:0] phase_thr [PHASE_COUNT];
      // Drive every input to a known value before the first edge
      reset      = 1'b1;
      req_tvalid = 1'b0;
      req_tdata  = '0;
      csr_tvalid = 1'b0;
      csr_tdata  = '0;
      no_gaps    = 1'b0;
      repeat (6) @(negedge clock);
      reset <= 1'b0;

      // Directed points, threshold at its reset value
      // Unit move over 11 points: start, middle and end of the profile
      send_request(32'h0000_0000, 32'h0001_0000, 13'd11, 12'd0);
      send_request(32'h0000_0000, 32'h0001_0000, 13'd11, 12'd5);
      send_request(32'h0000_0000, 32'h0001_0000, 13'd11, 12'd10);
      // Inside the start and end blends
      send_request(32'h0000_0000, 32'h0001_0000, 13'd101, 12'd3);
      send_request(32'h0000_0000, 32'h0001_0000, 13'd101, 12'd97);
      // Widest move, either side of both blend boundaries
      send_request(32'h8000_0000, 32'h7FFF_FFFF, 13'd4096, 12'd0);
      send_request(32'h8000_0000, 32'h7FFF_FFFF, 13'd4096, 12'd216);
      send_request(32'h8000_0000, 32'h7FFF_FFFF, 13'd4096, 12'd217);
      send_request(32'h8000_0000, 32'h7FFF_FFFF, 13'd4096, 12'd3878);
      send_request(32'h8000_0000, 32'h7FFF_FFFF, 13'd4096, 12'd3879);
      send_request(32'h8000_0000, 32'h7FFF_FFFF, 13'd4096, 12'd4095);
      // Widest move downwards
      send_request(32'h7FFF_FFFF, 32'h8000_0000, 13'd4096, 12'd1000);
      // Single point, then index errors: zero count, count over the limit, index too high
      send_request(32'h1234_5678, 32'hEDCB_A987, 13'd1, 12'd0);
      send_request(32'h1234_5678, 32'hEDCB_A987, 13'd0, 12'd0);
      send_request(32'h1234_5678, 32'hEDCB_A987, 13'd4097, 12'd5);
      send_request(32'hFFFF_FFFF, 32'h0000_0000, 13'd8191, 12'd4095);
      send_request(32'h0000_1000, 32'h0002_0000, 13'd100, 12'd100);
      // Still move at the threshold, just past it, and downwards
      send_request(32'h0000_1000, 32'h0000_1042, 13'd3, 12'd1);
      send_request(32'h0000_1000, 32'h0000_1043, 13'd3, 12'd1);
      send_request(32'h0000_1000, 32'h0000_0FBE, 13'd50, 12'd20);
      // Two-point move
      send_request(32'hFFFF_0000, 32'h0003_0000, 13'd2, 12'd0);
      send_request(32'hFFFF_0000, 32'h0003_0000, 13'd2, 12'd1);
      // Midpoint halves round away from zero
      send_request(32'h0000_0000, 32'h0000_0101, 13'd3, 12'd1);
      send_request(32'h0000_0000, 32'hFFFF_FEFF, 13'd3, 12'd1);

      // Random phases, each under its own threshold; the extremes come first
      phase_thr[0] = 16'd0;
      phase_thr[1] = 16'hFFFF;
      phase_thr[2] = 16'($urandom);
      phase_thr[3] = 16'd1;
      phase_thr[4] = 16'($urandom_range(0, 255));
      phase_thr[5] = STILL_RESET;
      for (int p = 0; p < PHASE_COUNT; p++) begin
         drain_pipeline();
         write_threshold(phase_thr[p]);
         // Run one phase back to back so the pipeline fills under pure stall pressure
         no_gaps = (p == 2);
         for (int n_item = 0; n_item < PHASE_ITEMS; n_item++) random_request();
      end

      // Let the pipeline empty, then wait out its latency for anything stray
      drain_pipeline();
      repeat (2 * PIPE_LATENCY) @(negedge clock);
      if (sb.outstanding() != 0) begin
         $error("%0d predicted points never came back", sb.outstanding());
      end
      if (sb.fail_count == 0 && sb.outstanding() == 0) begin
         $display("TEST PASSED");
      end else begin
         $display("TEST FAILED");
      end
      $finish;
   end

endmodule

// File: filelist.f
hw/rtl/btp_pkg.sv
hw/rtl/btp_prep.sv
hw/rtl/btp_div.sv
hw/rtl/btp_post.sv
hw/rtl/blended_trajectory_point.sv
bench/tb_top.sv
